FILE: rtl/assert_macros.svh
// assertion helpers used by the pool core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SCBP_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("scbp assertion failed");

// condition implies a consequence on the next edge
`define SCBP_ASSERT_NEXT(lbl, clk_s, rst_n_s, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond) |=> (cons)) \
		else $error("scbp assertion failed");

`endif

FILE: rtl/scbp_pkg.sv
package scbp_pkg;

	localparam int BYTE_W    = 15;
	localparam int LEN_W     = BYTE_W + 1;
	localparam int CFG_BINS  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 15;
	localparam int TOTAL_W   = 9;

	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_DEINIT  = 3'd1,
		CMD_ALLOC   = 3'd2,
		CMD_RETAIN  = 3'd3,
		CMD_RELEASE = 3'd4,
		CMD_PUSH    = 3'd5,
		CMD_PULL    = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_NO_FIT     = 3'd1,
		STS_BAD_HANDLE = 3'd2,
		STS_SHORT      = 3'd3,
		STS_INACTIVE   = 3'd4,
		STS_REF_OVF    = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [14:0] request_bytes;
		logic [14:0] headroom_bytes;
		logic [1:0]  bin_select;
		logic [7:0]  slot_select;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  out_bin;
		logic [7:0]  out_slot;
		logic [14:0] data_offset;
		logic [14:0] data_length;
		logic [14:0] tail_bytes;
		logic [7:0]  references;
		logic [8:0]  bin_used;
		logic [8:0]  bin_peak;
	} out_t;

endpackage

FILE: rtl/scbp_ram.sv
module scbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/size_class_buffer_pool_core.sv
// Packet buffer pool with up to four size classes. Each request (init, deinit, alloc,
// retain, release, push, pull) is taken when the block is idle and its output register
// is free, reads the slot and free-stack memories when it is taken and writes back in the
// cycle after, in the execute state; its result then waits in the output register until taken.
// After reset and after each deinit the slot memory (NUM_BINS*SLOTS_PER_BIN entries,
// 1024 by default) is swept clear at one entry per cycle, and no request is taken
// during that sweep; configuration writes are taken at any time.
`include "assert_macros.svh"

module size_class_buffer_pool_core #(
	parameter int NUM_BINS        = 4,
	parameter int SLOTS_PER_BIN   = 256,
	parameter int MAX_CHUNK_BYTES = 16384,
	parameter int LINE_BYTES      = 64,
	parameter int REF_BITS        = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  scbp_pkg::in_t                     in_req,
	output logic                              out_valid,
	input  logic                              out_stall,
	output scbp_pkg::out_t                    out_rsp,
	input  logic                              cfg_we,
	input  logic [scbp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scbp_pkg::CFG_W-1:0]        cfg_data
);
	import scbp_pkg::*;

	localparam int SLOT_AW = $clog2(SLOTS_PER_BIN);
	localparam int CNT_W   = $clog2(SLOTS_PER_BIN + 1);
	localparam int DEPTH   = NUM_BINS * SLOTS_PER_BIN;
	localparam int MEM_AW  = $clog2(DEPTH);
	localparam int BIDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int ACT_W   = $clog2(NUM_BINS + 1);
	localparam int CAP_W   = $clog2(MAX_CHUNK_BYTES + 1);
	localparam int MW      = REF_BITS + 2 * LEN_W;
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

	// configuration registers
	logic [CFG_W-1:0]   chunk_cfg_q [CFG_BINS];
	logic [TOTAL_W-1:0] total_cfg_q [CFG_BINS];

	// per-bin state
	logic [CAP_W-1:0] cap_q   [NUM_BINS];
	logic [CNT_W-1:0] slots_q [NUM_BINS];
	logic [CNT_W-1:0] fill_q  [NUM_BINS];
	logic [CNT_W-1:0] low_q   [NUM_BINS];
	logic [CNT_W-1:0] used_q  [NUM_BINS];
	logic [CNT_W-1:0] peak_q  [NUM_BINS];
	logic [ACT_W-1:0] active_q;

	state_t state_q, state_d;
	logic   clr_busy_q;
	logic [MEM_AW-1:0] clr_cnt_q;
	logic   accept;
	logic   out_valid_q;
	out_t   out_rsp_q;

	// request stage
	logic [2:0]        cmd_s1;
	logic [BYTE_W-1:0] req_s1, head_s1;
	logic [1:0]        bin_s1;
	logic [7:0]        slot_s1;
	logic [BIDX_W-1:0] bidx_s1, asel_s1;
	logic              afound_s1;

	// memory ports
	logic              slot_we, stk_we, mem_we, exec_wr;
	logic [MEM_AW-1:0] slot_waddr, slot_raddr, stk_waddr, stk_raddr, mem_waddr, exec_waddr;
	logic [MW-1:0]     slot_wdata, slot_rd, exec_wdata;
	logic [SLOT_AW-1:0] stk_wdata, stk_rd;

	// init values
	logic [CAP_W-1:0] init_cap [NUM_BINS];
	logic [CNT_W-1:0] init_cnt [NUM_BINS];
	logic [ACT_W-1:0] init_act;
	logic             init_go;
	logic [31:0]      init_rnd;

	// alloc search
	logic [BYTE_W:0]   need;
	logic [BIDX_W-1:0] asel;
	logic              afound;
	logic [BIDX_W-1:0] in_bidx;
	logic [SLOT_AW-1:0] in_sidx;

	// execute results
	logic [REF_BITS-1:0] m_ref, n_ref;
	logic [LEN_W-1:0]    m_head, m_len, n_head, n_len;
	logic                handle_ok, rep;
	logic [CNT_W-1:0]    a_top;
	logic [SLOT_AW-1:0]  a_slot;
	logic                upd_en;
	logic [BIDX_W-1:0]   upd_bin;
	logic [CNT_W-1:0]    upd_fill, upd_low, upd_used, upd_peak;
	logic [BIDX_W-1:0]   r_bin;
	logic [SLOT_AW-1:0]  r_slot;
	logic [31:0]         tail32;
	out_t                rsp;

	scbp_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	scbp_ram #(.WIDTH(SLOT_AW), .DEPTH(DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_BINS; i++) begin
				chunk_cfg_q[i] <= '0;
				total_cfg_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_IDX_W'(CFG_BINS)) begin
				chunk_cfg_q[cfg_index[1:0]] <= cfg_data;
			end else begin
				total_cfg_q[cfg_index[1:0]] <= cfg_data[TOTAL_W-1:0];
			end
		end
	end

	// init: latch leading nonzero bins, round up to whole lines and clamp to the maximums
	always_comb begin
		init_go  = 1'b1;
		init_act = '0;
		init_rnd = '0;
		for (int i = 0; i < NUM_BINS; i++) begin
			init_cap[i] = '0;
			init_cnt[i] = '0;
			if (init_go && chunk_cfg_q[i] != '0) begin
				init_rnd = ((32'(chunk_cfg_q[i]) + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
				init_cap[i] = (init_rnd > MAX_CHUNK_BYTES) ? CAP_W'(MAX_CHUNK_BYTES)
					: CAP_W'(init_rnd);
				init_cnt[i] = (32'(total_cfg_q[i]) > SLOTS_PER_BIN) ? CNT_W'(SLOTS_PER_BIN)
					: CNT_W'(total_cfg_q[i]);
				init_act = ACT_W'(i + 1);
			end else begin
				init_go = 1'b0;
			end
		end
	end

	// alloc: first latched bin that fits and has a free slot
	always_comb begin
		need   = (BYTE_W+1)'(in_req.request_bytes) + (BYTE_W+1)'(in_req.headroom_bytes);
		asel   = '0;
		afound = 1'b0;
		for (int i = 0; i < NUM_BINS; i++) begin
			if (!afound && 32'(i) < 32'(active_q) && 32'(cap_q[i]) >= 32'(need)
					&& fill_q[i] != '0) begin
				asel   = BIDX_W'(i);
				afound = 1'b1;
			end
		end
	end

	// read addresses, issued with the request
	always_comb begin
		in_bidx = (32'(in_req.bin_select) < NUM_BINS) ? BIDX_W'(in_req.bin_select) : '0;
		in_sidx = (32'(in_req.slot_select) < SLOTS_PER_BIN) ? SLOT_AW'(in_req.slot_select) : '0;
		slot_raddr = MEM_AW'(in_bidx) * MEM_AW'(SLOTS_PER_BIN) + MEM_AW'(in_sidx);
		stk_raddr  = MEM_AW'(asel) * MEM_AW'(SLOTS_PER_BIN)
			+ MEM_AW'(SLOT_AW'(fill_q[asel] - CNT_W'(1)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: in_stall = clr_busy_q || (out_valid_q && out_stall);
			S_EXEC: in_stall = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request stage capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= in_req.command;
			req_s1    <= in_req.request_bytes;
			head_s1   <= in_req.headroom_bytes;
			bin_s1    <= in_req.bin_select;
			slot_s1   <= in_req.slot_select;
			bidx_s1   <= in_bidx;
			asel_s1   <= asel;
			afound_s1 <= afound;
		end
	end

	assign m_ref  = slot_rd[MW-1 -: REF_BITS];
	assign m_head = slot_rd[2*LEN_W-1 -: LEN_W];
	assign m_len  = slot_rd[LEN_W-1:0];

	// execute: modify the read entry and build the result
	always_comb begin
		rsp        = '0;
		rep        = 1'b0;
		exec_wr    = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = '0;
		upd_en     = 1'b0;
		upd_bin    = bidx_s1;
		upd_fill   = fill_q[bidx_s1];
		upd_low    = low_q[bidx_s1];
		upd_used   = used_q[bidx_s1];
		upd_peak   = peak_q[bidx_s1];
		n_ref      = m_ref;
		n_head     = m_head;
		n_len      = m_len;
		r_bin      = bidx_s1;
		r_slot     = SLOT_AW'(slot_s1);
		a_top      = fill_q[asel_s1] - CNT_W'(1);
		a_slot     = (a_top < low_q[asel_s1]) ? SLOT_AW'(a_top) : stk_rd;
		handle_ok  = (32'(bin_s1) < 32'(active_q)) && (32'(slot_s1) < 32'(slots_q[bidx_s1]))
			&& m_ref != '0;
		tail32     = '0;
		case (cmd_s1) inside
			CMD_INIT, CMD_DEINIT: rsp.status = STS_OK;
			CMD_ALLOC, CMD_RETAIN, CMD_RELEASE, CMD_PUSH, CMD_PULL: begin
				if (active_q == '0) begin
					rsp.status = STS_INACTIVE;
				end else if (cmd_s1 == CMD_ALLOC) begin
					if (!afound_s1) begin
						rsp.status = STS_NO_FIT;
					end else begin
						rep      = 1'b1;
						exec_wr  = 1'b1;
						upd_en   = 1'b1;
						upd_bin  = asel_s1;
						r_bin    = asel_s1;
						r_slot   = a_slot;
						n_ref    = REF_BITS'(1);
						n_head   = LEN_W'(head_s1);
						n_len    = LEN_W'(req_s1);
						upd_fill = a_top;
						upd_low  = (a_top < low_q[asel_s1]) ? a_top : low_q[asel_s1];
						upd_used = used_q[asel_s1] + CNT_W'(1);
						upd_peak = (upd_used > peak_q[asel_s1]) ? upd_used : peak_q[asel_s1];
					end
				end else if (!handle_ok) begin
					rsp.status   = STS_BAD_HANDLE;
					rsp.out_bin  = bin_s1;
					rsp.out_slot = slot_s1;
				end else begin
					rep = 1'b1;
					case (cmd_s1)
						CMD_RETAIN: begin
							if (m_ref == REF_MAX) begin
								rsp.status = STS_REF_OVF;
							end else begin
								n_ref   = m_ref + REF_BITS'(1);
								exec_wr = 1'b1;
							end
						end
						CMD_RELEASE: begin
							exec_wr = 1'b1;
							n_ref   = m_ref - REF_BITS'(1);
							if (n_ref == '0) begin
								upd_en = 1'b1;
								n_head = '0;
								n_len  = '0;
								if (32'(fill_q[bidx_s1]) < SLOTS_PER_BIN) begin
									stk_we    = (state_q == S_EXEC);
									stk_waddr = MEM_AW'(bidx_s1) * MEM_AW'(SLOTS_PER_BIN)
										+ MEM_AW'(SLOT_AW'(fill_q[bidx_s1]));
									stk_wdata = SLOT_AW'(slot_s1);
									upd_fill  = fill_q[bidx_s1] + CNT_W'(1);
								end
								if (used_q[bidx_s1] != '0) begin
									upd_used = used_q[bidx_s1] - CNT_W'(1);
								end
							end
						end
						CMD_PUSH: begin
							if (32'(m_head) < 32'(req_s1)) begin
								rsp.status = STS_SHORT;
							end else begin
								exec_wr = 1'b1;
								n_head  = m_head - LEN_W'(req_s1);
								n_len   = m_len + LEN_W'(req_s1);
							end
						end
						default: begin
							if (32'(m_len) < 32'(req_s1)) begin
								rsp.status = STS_SHORT;
							end else begin
								exec_wr = 1'b1;
								n_len   = m_len - LEN_W'(req_s1);
								n_head  = m_head + LEN_W'(req_s1);
							end
						end
					endcase
				end
			end
			default: rsp.status = STS_OK;
		endcase
		// report of the buffer after the step
		if (rep) begin
			tail32 = (32'(cap_q[r_bin]) >= 32'(n_head) + 32'(n_len))
				? 32'(cap_q[r_bin]) - 32'(n_head) - 32'(n_len) : '0;
			rsp.out_bin     = 2'(r_bin);
			rsp.out_slot    = 8'(r_slot);
			rsp.data_offset = n_head[BYTE_W-1:0];
			rsp.data_length = n_len[BYTE_W-1:0];
			rsp.tail_bytes  = tail32[BYTE_W-1:0];
			rsp.references  = 8'(n_ref);
			rsp.bin_used    = 9'(upd_en ? upd_used : used_q[r_bin]);
			rsp.bin_peak    = 9'(upd_en ? upd_peak : peak_q[r_bin]);
		end
		exec_waddr = MEM_AW'(r_bin) * MEM_AW'(SLOTS_PER_BIN) + MEM_AW'(r_slot);
		exec_wdata = {n_ref, n_head, n_len};
	end

	// slot memory write: clearing sweep or write-back
	assign slot_we    = (state_q == S_EXEC) && exec_wr;
	assign mem_we     = clr_busy_q || slot_we;
	assign mem_waddr  = clr_busy_q ? clr_cnt_q : exec_waddr;
	assign slot_wdata = clr_busy_q ? '0 : exec_wdata;

	// clearing sweep after reset and deinit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (state_q == S_EXEC && cmd_s1 == CMD_DEINIT) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == MEM_AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
		end
	end

	// bin registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < NUM_BINS; i++) begin
				cap_q[i]   <= '0;
				slots_q[i] <= '0;
				fill_q[i]  <= '0;
				low_q[i]   <= '0;
				used_q[i]  <= '0;
				peak_q[i]  <= '0;
			end
		end else if (state_q == S_EXEC) begin
			if (cmd_s1 == CMD_INIT) begin
				if (active_q == '0) begin
					active_q <= init_act;
					for (int i = 0; i < NUM_BINS; i++) begin
						cap_q[i]   <= init_cap[i];
						slots_q[i] <= init_cnt[i];
						fill_q[i]  <= init_cnt[i];
						low_q[i]   <= init_cnt[i];
						used_q[i]  <= '0;
						peak_q[i]  <= '0;
					end
				end
			end else if (cmd_s1 == CMD_DEINIT) begin
				active_q <= '0;
				for (int i = 0; i < NUM_BINS; i++) begin
					cap_q[i]   <= '0;
					slots_q[i] <= '0;
					fill_q[i]  <= '0;
					low_q[i]   <= '0;
					used_q[i]  <= '0;
					peak_q[i]  <= '0;
				end
			end else if (upd_en) begin
				fill_q[upd_bin] <= upd_fill;
				low_q[upd_bin]  <= upd_low;
				used_q[upd_bin] <= upd_used;
				peak_q[upd_bin] <= upd_peak;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EXEC) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			out_rsp_q <= rsp;
		end
	end

	`SCBP_ASSERT(a_clear_blocks, clk, arst_n, !clr_busy_q || in_stall)
	`SCBP_ASSERT_NEXT(a_exec_once, clk, arst_n, state_q == S_EXEC, state_q == S_IDLE && out_valid_q)
	`SCBP_ASSERT(a_slots_balance, clk, arst_n, (32'(fill_q[0]) + 32'(used_q[0])) == 32'(slots_q[0]))

endmodule
